/* sv/rhrs_pkg.sv */
package rhrs_pkg;

   localparam int BANKS       = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_OUT     = 8;
   localparam int BANK_W      = $clog2(BANKS);
   localparam int POS_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = POS_W + 1;
   localparam int VISIT_W     = $clog2(BANKS + 1);
   localparam int ISSUE_W     = 4;
   localparam int MEM_DEPTH   = BANKS * QUEUE_DEPTH;
   localparam int MEM_AW      = BANK_W + POS_W;
   localparam int ADDR_W      = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ISSUE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_CAP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_SHIFT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_SHIFT    = 2'd3;

   localparam logic KIND_ENQ  = 1'b0;
   localparam logic KIND_TICK = 1'b1;
   localparam logic RES_ENQ   = 1'b0;
   localparam logic RES_ISSUE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [15:0]       req_id;
      logic [ADDR_W-1:0] address;
      logic              is_write;
      logic [12:0]       num_bytes;
      logic [7:0]        accept_mask;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [15:0]       out_id;
      logic [ADDR_W-1:0] out_address;
      logic              out_write;
      logic [12:0]       out_bytes;
      logic [2:0]        out_bank;
      logic              row_hit;
      logic              queue_full;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [15:0]       id;
      logic              wr;
      logic [12:0]       bytes;
   } entry_type;

   typedef struct packed {
      logic [3:0] issue_limit;
      logic [7:0] hit_cap;
      logic [5:0] row_shift;
      logic [5:0] line_shift;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      entry_type         wdata;
      logic [MEM_AW-1:0] raddr;
   } mem_req_type;

endpackage

/* sv/rhrs_ram.sv */
module rhrs_ram #(
   parameter int WIDTH = 78,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/rhrs_sched.sv */
module rhrs_sched
   import rhrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output mem_req_type mem_req,
   input  entry_type   mem_rdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_ENQ   = 10'b0000000010,
      S_SCAN  = 10'b0000000100,
      S_SRCH  = 10'b0000001000,
      S_OLD   = 10'b0000010000,
      S_OLDW  = 10'b0000100000,
      S_EMIT  = 10'b0001000000,
      S_SHIFT = 10'b0010000000,
      S_NEXT  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [BANK_W-1:0]  bank_ff, bank_in;
   logic [BANK_W-1:0]  next_bank_ff, next_bank_in;
   logic [VISIT_W-1:0] visit_ff, visit_in;
   logic [ISSUE_W-1:0] issued_ff, issued_in;
   logic [7:0]         mask_ff, mask_in;
   logic [CNT_W-1:0]   cnt_ff [BANKS];
   logic [CNT_W-1:0]   cnt_in [BANKS];
   logic               rvld_ff [BANKS];
   logic               rvld_in [BANKS];
   logic [7:0]         hitc_ff [BANKS];
   logic [7:0]         hitc_in [BANKS];
   logic [ADDR_W-1:0]  orow_ff [BANKS];
   logic [ADDR_W-1:0]  orow_in [BANKS];
   logic [CNT_W-1:0]   rd_pos_ff, rd_pos_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [POS_W-1:0]   cmp_pos_ff, cmp_pos_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   wpos_ff, wpos_in;
   logic               wvld_ff, wvld_in;
   rsp_type            rec_ff, rec_in;
   rsp_type            pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   rsp_type            out_ff, out_in;
   logic               out_vld_ff, out_vld_in;

   logic               out_free;
   logic [CNT_W-1:0]   cur_cnt;
   logic [ADDR_W-1:0]  row_of;
   logic [7:0]         limit;
   logic [BANK_W-1:0]  enq_bank;
   logic               enq_full;
   logic [BANK_W-1:0]  bank_wrap;

   function automatic rsp_type issue_rec(entry_type e, logic [BANK_W-1:0] b, logic hit);
      rsp_type r;
      r             = '0;
      r.result_kind = RES_ISSUE;
      r.out_id      = e.id;
      r.out_address = e.addr;
      r.out_write   = e.wr;
      r.out_bytes   = e.bytes;
      r.out_bank    = 3'(b);
      r.row_hit     = hit;
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign cur_cnt   = cnt_ff[bank_ff];
   assign row_of    = mem_rdata.addr >> cfg.row_shift;
   assign limit     = (cfg.hit_cap == 8'd0) ? 8'd1 : cfg.hit_cap;
   assign enq_bank  = BANK_W'(req_data.address >> cfg.line_shift);
   assign enq_full  = cnt_ff[enq_bank] >= CNT_W'(QUEUE_DEPTH);
   assign bank_wrap = (bank_ff == BANK_W'(BANKS - 1)) ? '0 : BANK_W'(bank_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      next_bank_in = next_bank_ff;
      visit_in     = visit_ff;
      issued_in    = issued_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rvld_in      = rvld_ff;
      hitc_in      = hitc_ff;
      orow_in      = orow_ff;
      rd_pos_in    = rd_pos_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_pos_in   = cmp_pos_ff;
      pos_in       = pos_ff;
      wpos_in      = wpos_ff;
      wvld_in      = wvld_ff;
      rec_in       = rec_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      mem_req       = '0;
      mem_req.raddr = {bank_ff, POS_W'(0)};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == KIND_ENQ) begin
                  if (!enq_full) begin
                     mem_req.we          = 1'b1;
                     mem_req.waddr       = {enq_bank, cnt_ff[enq_bank][POS_W-1:0]};
                     mem_req.wdata.addr  = req_data.address;
                     mem_req.wdata.id    = req_data.req_id;
                     mem_req.wdata.wr    = req_data.is_write;
                     mem_req.wdata.bytes = req_data.num_bytes;
                     cnt_in[enq_bank]    = CNT_W'(cnt_ff[enq_bank] + 1'b1);
                  end
                  rec_in             = '0;
                  rec_in.result_kind = RES_ENQ;
                  rec_in.out_id      = req_data.req_id;
                  rec_in.out_bank    = 3'(enq_bank);
                  rec_in.queue_full  = enq_full;
                  rec_in.last        = 1'b1;
                  state_in           = S_ENQ;
               end else begin
                  mask_in   = req_data.accept_mask;
                  bank_in   = next_bank_ff;
                  visit_in  = '0;
                  issued_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_ENQ: begin
            if (out_free) begin
               out_in     = rec_ff;
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            if (cur_cnt != '0 && mask_ff[3'(bank_ff)]) begin
               if (rvld_ff[bank_ff] && hitc_ff[bank_ff] < limit) begin
                  rd_pos_in  = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = S_SRCH;
               end else begin
                  state_in = S_OLD;
               end
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SRCH: begin
            mem_req.raddr = {bank_ff, rd_pos_ff[POS_W-1:0]};
            if (rd_pos_ff < cur_cnt) begin
               rd_pos_in  = CNT_W'(rd_pos_ff + 1'b1);
               cmp_vld_in = 1'b1;
               cmp_pos_in = rd_pos_ff[POS_W-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff) begin
               if (row_of == orow_ff[bank_ff]) begin
                  rec_in           = issue_rec(mem_rdata, bank_ff, 1'b1);
                  pos_in           = cmp_pos_ff;
                  hitc_in[bank_ff] = 8'(hitc_ff[bank_ff] + 1'b1);
                  state_in         = S_EMIT;
               end else if (CNT_W'(cmp_pos_ff) + CNT_W'(1) == cur_cnt) begin
                  state_in = S_OLD;
               end
            end
         end
         S_OLD: begin
            mem_req.raddr = {bank_ff, POS_W'(0)};
            state_in      = S_OLDW;
         end
         S_OLDW: begin
            rec_in           = issue_rec(mem_rdata, bank_ff, 1'b0);
            pos_in           = '0;
            orow_in[bank_ff] = row_of;
            rvld_in[bank_ff] = 1'b1;
            hitc_in[bank_ff] = 8'd1;
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_in     = pend_ff;
                  out_vld_in = 1'b1;
               end
               pend_in      = rec_ff;
               pend_vld_in  = 1'b1;
               issued_in    = ISSUE_W'(issued_ff + 1'b1);
               next_bank_in = bank_wrap;
               rd_pos_in    = CNT_W'(pos_ff) + CNT_W'(1);
               wvld_in      = 1'b0;
               state_in     = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (rd_pos_ff < cur_cnt) begin
               mem_req.raddr = {bank_ff, rd_pos_ff[POS_W-1:0]};
               rd_pos_in     = CNT_W'(rd_pos_ff + 1'b1);
               wvld_in       = 1'b1;
               wpos_in       = POS_W'(rd_pos_ff - 1'b1);
            end else begin
               wvld_in = 1'b0;
            end
            if (wvld_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = {bank_ff, wpos_ff};
               mem_req.wdata = mem_rdata;
            end else if (rd_pos_ff >= cur_cnt) begin
               cnt_in[bank_ff] = CNT_W'(cur_cnt - 1'b1);
               if ((cfg.issue_limit != 4'd0 && issued_ff == cfg.issue_limit) ||
                   issued_ff >= ISSUE_W'(MAX_OUT)) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            bank_in  = bank_wrap;
            visit_in = VISIT_W'(visit_ff + 1'b1);
            if (visit_ff == VISIT_W'(BANKS - 1)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_FIN: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in      = pend_ff;
               out_in.last = 1'b1;
               out_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_bank_ff <= '0;
         out_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         wvld_ff      <= 1'b0;
         for (int b = 0; b < BANKS; b++) begin
            cnt_ff[b]  <= '0;
            rvld_ff[b] <= 1'b0;
            hitc_ff[b] <= 8'd1;
         end
      end else begin
         state_ff     <= state_in;
         next_bank_ff <= next_bank_in;
         out_vld_ff   <= out_vld_in;
         pend_vld_ff  <= pend_vld_in;
         cmp_vld_ff   <= cmp_vld_in;
         wvld_ff      <= wvld_in;
         cnt_ff       <= cnt_in;
         rvld_ff      <= rvld_in;
         hitc_ff      <= hitc_in;
      end
      bank_ff    <= bank_in;
      visit_ff   <= visit_in;
      issued_ff  <= issued_in;
      mask_ff    <= mask_in;
      orow_ff    <= orow_in;
      rd_pos_ff  <= rd_pos_in;
      cmp_pos_ff <= cmp_pos_in;
      pos_ff     <= pos_in;
      wpos_ff    <= wpos_in;
      rec_ff     <= rec_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

endmodule

/* sv/row_hit_request_scheduler_top.sv */
// channel  | handshake               | beat
// ---------+-------------------------+-------------------------------------
// req      | req_valid / req_ready   | req_data: enqueue or tick
// rsp      | rsp_valid / rsp_ready   | rsp_data: enqueue status or issue
// csr      | csr_valid / csr_ready   | csr_index, csr_wdata
//
// Enqueue: the status beat waits in S_ENQ for a free output slot; req_ready returns in
// the same cycle that the beat turns valid. Tick: a bank that does not issue passes
// through scan and advance; a bank that issues finds its beat (scan, row search, oldest
// read), hands it on, closes the queue gap and advances; S_FIN ends the tick.
// Reset clears queue counts, row-valid bits and bank pointer; queue memory is not
// cleared. req_ready is low while an item is in work; a held rsp beat stalls issue.
module row_hit_request_scheduler_top
   import rhrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   mem_req_type mem_req;
   entry_type   mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ISSUE_LIMIT:   cfg_in.issue_limit   = csr_wdata[3:0];
            CSR_HIT_CAP:       cfg_in.hit_cap       = csr_wdata;
            CSR_ROW_SHIFT:     cfg_in.row_shift     = csr_wdata[5:0];
            CSR_LINE_SHIFT:    cfg_in.line_shift    = csr_wdata[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.issue_limit   <= 4'd0;
         cfg_ff.hit_cap       <= 8'd1;
         cfg_ff.row_shift     <= 6'd13;
         cfg_ff.line_shift    <= 6'd6;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rhrs_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   rhrs_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

`ifndef SYNTH
   a_enq_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RES_ENQ |-> rsp_data.last && !rsp_data.row_hit)
      else $error("enqueue beat without last or with row hit");

   a_issue_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == RES_ISSUE |-> !rsp_data.queue_full)
      else $error("issue beat flagged queue full");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_TICK |=> !req_ready)
      else $error("ready right after tick accept");
`endif

endmodule

/* tb/row_hit_request_scheduler_top_test.sv */
`timescale 1ns / 1ps
module row_hit_request_scheduler_top_test;
   import rhrs_pkg::*;

   class sched_scoreboard;
      entry_type   bank_q[BANKS][$];
      logic [47:0] open_row[BANKS];
      bit          row_open[BANKS];
      int unsigned hit_count[BANKS];
      int unsigned rr_bank;
      cfg_type     cfg;
      rsp_type     pending[$];
      int          errors;

      function void clear();
         for (int b = 0; b < BANKS; b++) begin
            bank_q[b].delete();
            open_row[b] = '0;
            row_open[b] = 0;
            hit_count[b] = 1;
         end
         rr_bank = 0;
         cfg.issue_limit = 0;
         cfg.hit_cap = 1;
         cfg.row_shift = 13;
         cfg.line_shift = 6;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] v);
         case (idx)
            CSR_ISSUE_LIMIT: cfg.issue_limit = v[3:0];
            CSR_HIT_CAP: cfg.hit_cap = v;
            CSR_ROW_SHIFT: cfg.row_shift = v[5:0];
            default: cfg.line_shift = v[5:0];
         endcase
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         entry_type e;
         int unsigned bank, lim, issued, k;
         bit acc, tried;
         o = '0;
         if (r.kind == KIND_ENQ) begin
            bank = 32'((r.address >> cfg.line_shift) & (BANKS - 1));
            e.addr = r.address;
            e.id = r.req_id;
            e.wr = r.is_write;
            e.bytes = r.num_bytes;
            o.result_kind = RES_ENQ;
            o.out_id = r.req_id;
            o.out_bank = 3'(bank);
            o.last = 1;
            if (bank_q[bank].size() >= QUEUE_DEPTH) o.queue_full = 1;
            else bank_q[bank].insert(bank_q[bank].size(), e);
            pending.insert(pending.size(), o);
            return;
         end
         lim = (cfg.hit_cap == 0) ? 1 : cfg.hit_cap;
         bank = rr_bank;
         issued = 0;
         for (int i = 0; i < BANKS; i++) begin
            acc = r.accept_mask[bank % 8];
            tried = 0;
            if (bank_q[bank].size() != 0) begin
               if (row_open[bank] && hit_count[bank] < lim) begin
                  for (k = 0; k < bank_q[bank].size(); k++) begin
                     if ((bank_q[bank][k].addr >> cfg.row_shift) == open_row[bank]) begin
                        tried = 1;
                        if (acc) begin
                           e = bank_q[bank][k];
                           o = '0;
                           o.result_kind = RES_ISSUE;
                           o.out_id = e.id;
                           o.out_address = e.addr;
                           o.out_write = e.wr;
                           o.out_bytes = e.bytes;
                           o.out_bank = 3'(bank);
                           o.row_hit = 1;
                           pending.insert(pending.size(), o);
                           issued++;
                           rr_bank = (bank + 1) % BANKS;
                           hit_count[bank]++;
                           bank_q[bank].delete(k);
                        end
                        break;
                     end
                  end
               end
               if (!tried && acc) begin
                  e = bank_q[bank].pop_front();
                  o = '0;
                  o.result_kind = RES_ISSUE;
                  o.out_id = e.id;
                  o.out_address = e.addr;
                  o.out_write = e.wr;
                  o.out_bytes = e.bytes;
                  o.out_bank = 3'(bank);
                  pending.insert(pending.size(), o);
                  issued++;
                  rr_bank = (bank + 1) % BANKS;
                  hit_count[bank] = 1;
                  open_row[bank] = e.addr >> cfg.row_shift;
                  row_open[bank] = 1;
               end
               if ((cfg.issue_limit != 0 && issued == cfg.issue_limit) || issued >= MAX_OUT)
                  break;
            end
            bank = (bank + 1) % BANKS;
         end
         if (issued > 0) pending[pending.size() - 1].last = 1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: expected none actual %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("beat mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sched_scoreboard sb;
   bit quiet_phase;
   int idle_cycles;

   row_hit_request_scheduler_top dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      @(posedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [7:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task automatic send(req_type r);
      int n;
      csr_valid <= 1'b0;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 8);
         repeat (n) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic enqueue(logic [47:0] a, logic [15:0] id);
      req_type r;
      r = '0;
      r.kind = KIND_ENQ;
      r.req_id = id;
      r.address = a;
      r.is_write = 1'($urandom_range(0, 1));
      r.num_bytes = 13'($urandom_range(0, 4096));
      r.accept_mask = 8'($urandom);
      send(r);
   endtask

   task automatic tick(logic [7:0] m);
      req_type r;
      r = $bits(req_type)'({$urandom, $urandom, $urandom});
      r.kind = KIND_TICK;
      r.accept_mask = m;
      send(r);
   endtask

   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [47:0] pick_addr(int rows);
      logic [47:0] a;
      a = 48'({$urandom, $urandom});
      a = a & ((48'd1 << sb.cfg.row_shift) - 1);
      a = a | (48'($urandom_range(0, rows - 1)) << sb.cfg.row_shift);
      return a;
   endfunction

   initial begin
      req_type r;
      sb = new();
      sb.clear();
      quiet_phase = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ISSUE_LIMIT;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, full queue, refused hits, hit limit
      enqueue(48'hFFFF_FFFF_FFFF, 16'hFFFF);
      enqueue(48'h0, 16'h0);
      tick(8'h00);
      tick(8'hFF);
      for (int i = 0; i < 17; i++) enqueue(48'h40 * 8 * i[2:0], 16'(i));
      drain();
      csr_write(CSR_HIT_CAP, 8'd4);
      csr_write(CSR_ISSUE_LIMIT, 8'd2);
      tick(8'hFE);
      tick(8'hFF);
      drain();
      csr_write(CSR_HIT_CAP, 8'd0);
      tick(8'h01);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_ISSUE_LIMIT, 8'd0);
               csr_write(CSR_HIT_CAP, 8'd255);
               csr_write(CSR_ROW_SHIFT, 8'd47);
               csr_write(CSR_LINE_SHIFT, 8'd0);
            end
            1: begin
               csr_write(CSR_ISSUE_LIMIT, 8'd8);
               csr_write(CSR_HIT_CAP, 8'd3);
               csr_write(CSR_ROW_SHIFT, 8'd10);
               csr_write(CSR_LINE_SHIFT, 8'd6);
            end
            2: begin
               csr_write(CSR_ISSUE_LIMIT, 8'd15);
               csr_write(CSR_HIT_CAP, 8'd1);
               csr_write(CSR_ROW_SHIFT, 8'd0);
               csr_write(CSR_LINE_SHIFT, 8'd47);
            end
            3: begin
               csr_write(CSR_ISSUE_LIMIT, 8'd1);
               csr_write(CSR_HIT_CAP, 8'd8);
               csr_write(CSR_ROW_SHIFT, 8'd13);
               csr_write(CSR_LINE_SHIFT, 8'd3);
            end
            default: begin
               quiet_phase = 1;
               csr_write(CSR_ISSUE_LIMIT, 8'd0);
               csr_write(CSR_HIT_CAP, 8'd6);
            end
         endcase
         for (int i = 0; i < 16; i++) begin
            if ($urandom_range(0, 2) != 0) enqueue(pick_addr(3), 16'($urandom));
            else tick($urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom));
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/rhrs_pkg.sv
sv/rhrs_ram.sv
sv/rhrs_sched.sv
sv/row_hit_request_scheduler_top.sv
tb/row_hit_request_scheduler_top_test.sv
